### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property shorthands for the watchdog checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg
// shared constants and types of the miss-count watchdog
// ----------------------------------------------------------------------------
package mcw_pkg;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int MAX_CHANNELS     = 4;

   localparam int CMD_W     = 2;
   localparam int CHAN_W    = 2;
   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 16;
   localparam int GAP_W     = 8;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // commands
   localparam logic [CMD_W-1:0] CMD_KICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHECK_GAP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MISS_LIMIT = 3'd5;

   // reset values
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd60;
   localparam logic [GAP_W-1:0]     GAP_RST     = 8'd3;
   localparam logic [COUNT_W-1:0]   LIMIT_RST   = 8'd3;
   localparam logic [COUNT_W-1:0]   COUNT_MAX   = 8'd255;

   // per-channel strobes for one transaction
   typedef struct packed {
      logic              kick;
      logic              stop;
      logic              check;
      logic [TIME_W-1:0] now;
   } chan_ctl_type;

endpackage

### rtl/core/mcw_channel.sv
// ----------------------------------------------------------------------------
// mcw_channel
// one watched channel: last kick time, miss counter and expiry test
// ----------------------------------------------------------------------------
module mcw_channel (
   input  logic                                clock,
   input  logic                                reset,
   input  mcw_pkg::chan_ctl_type               ctl,
   input  logic [mcw_pkg::TIMEOUT_W-1:0]       timeout,
   input  logic [mcw_pkg::COUNT_W-1:0]         limit,
   output logic                                expired
);

   logic [mcw_pkg::TIME_W-1:0]  last_kick_ff, last_kick_in;
   logic [mcw_pkg::COUNT_W-1:0] miss_count_ff, miss_count_in;
   logic                        started;
   logic                        idle_hit;
   logic [mcw_pkg::TIME_W-1:0]  idle_time;

   assign started   = (last_kick_ff != '0);
   assign idle_time = ctl.now - last_kick_ff;
   // a kick in the future means not idle
   assign idle_hit  = (ctl.now >= last_kick_ff) &&
                      (idle_time >= {{(mcw_pkg::TIME_W-mcw_pkg::TIMEOUT_W){1'b0}}, timeout});

   always_comb begin
      last_kick_in  = last_kick_ff;
      miss_count_in = miss_count_ff;
      if (ctl.kick) begin
         last_kick_in = ctl.now;
      end else if (ctl.stop) begin
         last_kick_in = '0;
      end
      if (ctl.check && started) begin
         if (!idle_hit) begin
            miss_count_in = '0;
         end else if (miss_count_ff != mcw_pkg::COUNT_MAX) begin
            miss_count_in = miss_count_ff + 1'b1;
         end
      end
   end

   assign expired = ctl.check && started && (miss_count_in >= limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_kick_ff  <= '0;
         miss_count_ff <= '0;
      end else begin
         last_kick_ff  <= last_kick_in;
         miss_count_ff <= miss_count_in;
      end
   end

endmodule

### rtl/core/multi_channel_miss_count_watchdog.sv
// ----------------------------------------------------------------------------
// multi_channel_miss_count_watchdog
// software watchdog over several channels with per-channel miss counters
// ----------------------------------------------------------------------------
//   channel   ports                    moves
//   request   req_valid / req_stall    cmd, channel, now_sec
//   response  rsp_valid / rsp_stall    time_error, check_ran, mask, fire, latch
//   csr       csr_write_enable         csr_index, csr_data (write only)
//
// one transaction per cycle sustained while the response is not stalled; an accepted
//   request passes through the request register into the response register
// the evaluate stage (per-channel subtract and compare) sets the rate
// sync reset clears all watchdog state and config to defaults, no sweep
// a stalled response holds the evaluate stage; the request register then
//   fills and req_stall rises
// ----------------------------------------------------------------------------
module multi_channel_miss_count_watchdog #(
   parameter int NUM_CHANNELS = mcw_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mcw_pkg::CMD_W-1:0]         req_cmd,
   input  logic [mcw_pkg::CHAN_W-1:0]        req_channel,
   input  logic [mcw_pkg::TIME_W-1:0]        req_now_sec,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_time_error,
   output logic                              rsp_check_ran,
   output logic [mcw_pkg::MAX_CHANNELS-1:0]  rsp_expired_mask,
   output logic                              rsp_fire,
   output logic                              rsp_fired_latched,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [mcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mcw_pkg::CSR_DATA_W-1:0]    csr_data
);

   // ---------------- configuration registers ----------------
   logic [mcw_pkg::TIMEOUT_W-1:0] timeout_ff [NUM_CHANNELS];
   logic [mcw_pkg::GAP_W-1:0]     check_gap_ff;
   logic [mcw_pkg::COUNT_W-1:0]   miss_limit_ff;
   logic [mcw_pkg::COUNT_W-1:0]   eff_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_gap_ff  <= mcw_pkg::GAP_RST;
         miss_limit_ff <= mcw_pkg::LIMIT_RST;
      end else if (csr_write_enable) begin
         if (csr_index == mcw_pkg::REG_CHECK_GAP) begin
            check_gap_ff <= csr_data[mcw_pkg::GAP_W-1:0];
         end
         if (csr_index == mcw_pkg::REG_MISS_LIMIT) begin
            miss_limit_ff <= csr_data[mcw_pkg::COUNT_W-1:0];
         end
      end
   end

   // a zero limit behaves as one
   assign eff_limit = (miss_limit_ff == '0) ? mcw_pkg::COUNT_W'(1) : miss_limit_ff;

   // ---------------- request register ----------------
   logic                          s1_valid_ff, s1_valid_in;
   logic [mcw_pkg::CMD_W-1:0]     s1_cmd_ff;
   logic [mcw_pkg::CHAN_W-1:0]    s1_channel_ff;
   logic [mcw_pkg::TIME_W-1:0]    s1_now_ff;
   logic                          load_s1;
   logic                          advance;
   logic                          rsp_valid_ff, rsp_valid_in;

   // evaluate when the response register is empty or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign load_s1   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load_s1) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_cmd_ff     <= req_cmd;
         s1_channel_ff <= req_channel;
         s1_now_ff     <= req_now_sec;
      end
   end

   // ---------------- evaluate ----------------
   logic [mcw_pkg::TIME_W-1:0] last_check_ff, last_check_in;
   logic                       has_fired_ff, has_fired_in;
   logic                       time_ok;
   logic                       do_kick, do_stop, do_check;
   logic                       gap_pass;
   logic [NUM_CHANNELS-1:0]    expired_vec;
   logic                       fire;

   assign time_ok  = (s1_now_ff != '0);
   // 33-bit compare so the gap sum cannot wrap
   assign gap_pass = ({1'b0, s1_now_ff} >
                      ({1'b0, last_check_ff} +
                       {{(mcw_pkg::TIME_W+1-mcw_pkg::GAP_W){1'b0}}, check_gap_ff}));

   always_comb begin
      do_kick  = 1'b0;
      do_stop  = 1'b0;
      do_check = 1'b0;
      if (advance && time_ok) begin
         case (s1_cmd_ff)
            mcw_pkg::CMD_KICK:  do_kick  = 1'b1;
            mcw_pkg::CMD_STOP:  do_stop  = 1'b1;
            mcw_pkg::CMD_CHECK: do_check = gap_pass;
            default:            ; // unused command does nothing
         endcase
      end
   end

   // one channel unit per watched channel, all evaluated in parallel
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      mcw_pkg::chan_ctl_type ctl;
      logic                  sel;

      assign sel       = (s1_channel_ff == mcw_pkg::CHAN_W'(i));
      assign ctl.kick  = do_kick && sel;
      assign ctl.stop  = do_stop && sel;
      assign ctl.check = do_check;
      assign ctl.now   = s1_now_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            timeout_ff[i] <= mcw_pkg::TIMEOUT_RST;
         end else if (csr_write_enable &&
                      (csr_index == mcw_pkg::REG_TIMEOUT0 + mcw_pkg::CSR_IDX_W'(i))) begin
            timeout_ff[i] <= csr_data[mcw_pkg::TIMEOUT_W-1:0];
         end
      end

      mcw_channel u_chan (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .timeout (timeout_ff[i]),
         .limit   (eff_limit),
         .expired (expired_vec[i])
      );
   end

   // fire only on the first check that sees any expiry
   assign fire         = do_check && (expired_vec != '0) && !has_fired_ff;
   assign has_fired_in = has_fired_ff || fire;
   assign last_check_in = do_check ? s1_now_ff : last_check_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_check_ff <= '0;
         has_fired_ff  <= 1'b0;
      end else begin
         last_check_ff <= last_check_in;
         has_fired_ff  <= has_fired_in;
      end
   end

   // ---------------- response register ----------------
   logic                             rsp_time_error_ff;
   logic                             rsp_check_ran_ff;
   logic [mcw_pkg::MAX_CHANNELS-1:0] rsp_mask_ff;
   logic                             rsp_fire_ff;
   logic                             rsp_latched_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_time_error_ff <= !time_ok;
         rsp_check_ran_ff  <= do_check;
         rsp_mask_ff       <= mcw_pkg::MAX_CHANNELS'(expired_vec);
         rsp_fire_ff       <= fire;
         rsp_latched_ff    <= has_fired_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_time_error    = rsp_time_error_ff;
   assign rsp_check_ran     = rsp_check_ran_ff;
   assign rsp_expired_mask  = rsp_mask_ff;
   assign rsp_fire          = rsp_fire_ff;
   assign rsp_fired_latched = rsp_latched_ff;

endmodule

### rtl/core/mcw_checker.sv
// ----------------------------------------------------------------------------
// mcw_checker
// port-level checks on the watchdog response stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcw_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_time_error,
   input  logic                              rsp_check_ran,
   input  logic [mcw_pkg::MAX_CHANNELS-1:0]  rsp_expired_mask,
   input  logic                              rsp_fire,
   input  logic                              rsp_fired_latched
);

   logic seen_fired_ff;

   // remembers a delivered response that showed the latch set
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fired_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_fired_latched) begin
         seen_fired_ff <= 1'b1;
      end
   end

   `ASSERT_IMPLY(a_err_quiet, clock, reset, rsp_valid && (rsp_time_error || !rsp_check_ran),
                 !rsp_fire && (rsp_expired_mask == '0) && !(rsp_time_error && rsp_check_ran))

   `ASSERT_IMPLY(a_fire_cause, clock, reset, rsp_valid && rsp_fire,
                 rsp_fired_latched && rsp_check_ran && (rsp_expired_mask != '0))

   `ASSERT_IMPLY(a_latch_sticky, clock, reset, rsp_valid && seen_fired_ff,
                 rsp_fired_latched && !rsp_fire)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_expired_mask) && $stable(rsp_fire))

endmodule

bind multi_channel_miss_count_watchdog mcw_checker u_mcw_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_time_error    (rsp_time_error),
   .rsp_check_ran     (rsp_check_ran),
   .rsp_expired_mask  (rsp_expired_mask),
   .rsp_fire          (rsp_fire),
   .rsp_fired_latched (rsp_fired_latched)
);
